/* hw/rtl/phr_pkg.sv */
// Shared constants for the polarimetric HSV to RGB pixel pipeline.
// Register map, CORDIC tables, hue and color mixing coefficients. No dependencies.
`default_nettype none

package phr_pkg;

  localparam int CfgW = 18;

  typedef enum logic [1:0] {
    CFG_MIN_DB   = 2'd0,
    CFG_MAX_DB   = 2'd1,
    CFG_FLOOR_DB = 2'd2
  } cfg_idx_t;

  localparam logic signed [CfgW-1:0] MinDbReset   = -18'sd6400;
  localparam logic signed [CfgW-1:0] MaxDbReset   = 18'sd0;
  localparam logic signed [CfgW-1:0] FloorDbReset = -18'sd76800;

  // hue in Q.8 degrees
  localparam logic signed [18:0] HueBase   = 19'sd76800;
  localparam logic signed [18:0] HueFull   = 19'sd92160;
  localparam logic [16:0]        HueSector = 17'd15360;
  localparam logic [14:0]        Deg120Q8  = 15'd30720;

  // CORDIC, angles in Q.16 degrees, vectors in Q.30
  localparam int CordicN = 16;
  localparam int QuoW    = 17;
  localparam logic signed [33:0] CordicX0 = 34'sd652032874;
  localparam logic signed [25:0] Deg90    = 26'sd5898240;
  localparam logic signed [25:0] Deg180   = 26'sd11796480;
  localparam logic signed [25:0] Deg270   = 26'sd17694720;
  localparam logic signed [25:0] Deg360   = 26'sd23592960;
  localparam logic signed [25:0] CORDIC_ATAN [CordicN] = '{
    26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
    26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
    26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
    26'sd917,     26'sd458,     26'sd229,    26'sd115
  };

  // 10*log10(2) in Q.16
  localparam logic signed [18:0] DbPerOctave = 19'sd197283;
  localparam logic [15:0]        ChromaK     = 16'd56756;

  localparam logic signed [17:0] CoefRm1 = 18'sd51610;
  localparam logic signed [17:0] CoefRm2 = 18'sd24340;
  localparam logic signed [17:0] CoefGm1 = 18'sd13926;
  localparam logic signed [17:0] CoefGm2 = 18'sd13494;
  localparam logic signed [17:0] CoefBm2 = 18'sd62181;

endpackage

`default_nettype wire

/* hw/rtl/phr_cordic.sv */
// Pipelined rotation-mode CORDIC: Q.16 degree angle 0..360 to Q.16 sin and cos.
// Depends on phr_pkg (arctangent table, angle constants).
`default_nettype none

module phr_cordic import phr_pkg::*; (
  input  logic                clk,
  input  logic                en,
  input  logic [24:0]         angle,
  output logic signed [19:0]  sin_q,
  output logic signed [19:0]  cos_q
);

  logic signed [33:0] x  [0:CordicN];
  logic signed [33:0] y  [0:CordicN];
  logic signed [25:0] z  [0:CordicN];
  logic               ng [0:CordicN];
  logic signed [25:0] a;
  logic signed [33:0] xf;
  logic signed [33:0] yf;

  assign a  = $signed({1'b0, angle});
  assign xf = ng[CordicN] ? -x[CordicN] : x[CordicN];
  assign yf = ng[CordicN] ? -y[CordicN] : y[CordicN];

  always_ff @(posedge clk) begin
    if (en) begin
      // fold into -90..90, negate the result for the left half plane
      x[0] <= CordicX0;
      y[0] <= '0;
      if (a > Deg270) begin
        z[0]  <= a - Deg360;
        ng[0] <= 1'b0;
      end else if (a > Deg90) begin
        z[0]  <= a - Deg180;
        ng[0] <= 1'b1;
      end else begin
        z[0]  <= a;
        ng[0] <= 1'b0;
      end
      for (int k = 1; k <= CordicN; k++) begin
        ng[k] <= ng[k-1];
        if (z[k-1] >= 0) begin
          x[k] <= x[k-1] - (y[k-1] >>> (k-1));
          y[k] <= y[k-1] + (x[k-1] >>> (k-1));
          z[k] <= z[k-1] - CORDIC_ATAN[k-1];
        end else begin
          x[k] <= x[k-1] + (y[k-1] >>> (k-1));
          y[k] <= y[k-1] - (x[k-1] >>> (k-1));
          z[k] <= z[k-1] + CORDIC_ATAN[k-1];
        end
      end
      cos_q <= xf[33:14];
      sin_q <= yf[33:14];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/phr_div.sv */
// Pipelined restoring divider, one quotient bit per stage, QW stages.
// Needs r0 < den on entry; low bits are brought down MSB first. Uses phr_pkg.
`default_nettype none

module phr_div import phr_pkg::*; #(
  parameter int DW = 18,
  parameter int QW = QuoW
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] r0,
  input  logic [QW-1:0] low,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  logic [DW-1:0] rr [1:QW];
  logic [QW-1:0] lo [1:QW];
  logic [DW-1:0] dn [1:QW];
  logic [QW-1:0] qq [1:QW];

  logic [DW-1:0] ri [1:QW];
  logic [QW-1:0] li [1:QW];
  logic [DW-1:0] di [1:QW];
  logic [QW-1:0] qi [1:QW];
  logic [DW:0]   r2 [1:QW];
  logic [DW:0]   df [1:QW];
  logic          ge [1:QW];

  always_comb begin
    ri[1] = r0;
    li[1] = low;
    di[1] = den;
    qi[1] = '0;
    for (int j = 2; j <= QW; j++) begin
      ri[j] = rr[j-1];
      li[j] = lo[j-1];
      di[j] = dn[j-1];
      qi[j] = qq[j-1];
    end
    for (int j = 1; j <= QW; j++) begin
      r2[j] = {ri[j], li[j][QW-1]};
      df[j] = r2[j] - {1'b0, di[j]};
      ge[j] = (r2[j] >= {1'b0, di[j]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 1; j <= QW; j++) begin
        rr[j] <= ge[j] ? df[j][DW-1:0] : r2[j][DW-1:0];
        lo[j] <= {li[j][QW-2:0], 1'b0};
        dn[j] <= di[j];
        qq[j] <= {qi[j][QW-2:0], ge[j]};
      end
    end
  end

  assign quo = qq[QW];

endmodule

`default_nettype wire

/* hw/rtl/polarimetric_hsv_to_rgb_pixel_top.sv */
// Top level: alpha / entropy / eigenvalue pixel to 8-bit RGB, fully pipelined.
// Depends on phr_pkg, phr_cordic and phr_div.
//
//  channel | signals                                       | beat
//  pix     | pix_valid pix_ready alpha_deg entropy          | one pixel in
//          | lambda_bits pixel_valid                        |
//  rgb     | rgb_valid rgb_ready red green blue             | one color out
//  cfg     | cfg_we cfg_index cfg_data                      | register write
//
// One beat per clock sustained while the skid register stays empty.
// The pipeline depth is set by the 16-stage hue CORDIC, the 17-stage chroma divider
// behind it and the three rotate and mix stages.
// rst clears valid bits and the output skid flag, and loads the dB registers with their reset values.
// A stall freezes the pipeline only once the skid register fills; pix_ready
// is a register output with no path from rgb_ready.
`default_nettype none

module polarimetric_hsv_to_rgb_pixel_top import phr_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            pix_valid,
  output logic            pix_ready,
  input  logic [14:0]     alpha_deg,
  input  logic [15:0]     entropy,
  input  logic [31:0]     lambda_bits,
  input  logic            pixel_valid,
  output logic            rgb_valid,
  input  logic            rgb_ready,
  output logic [7:0]      red,
  output logic [7:0]      green,
  output logic [7:0]      blue,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [CfgW-1:0] cfg_data
);

  localparam int Last = 40;

  logic signed [CfgW-1:0] min_db;
  logic signed [CfgW-1:0] max_db;
  logic signed [CfgW-1:0] floor_db;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_db   <= MinDbReset;
      max_db   <= MaxDbReset;
      floor_db <= FloorDbReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_DB:   min_db   <= cfg_data;
        CFG_MAX_DB:   max_db   <= cfg_data;
        CFG_FLOOR_DB: floor_db <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  logic skid_v;
  logic out_v;
  logic push;
  logic vld [1:Last];
  logic pv  [1:Last];

  assign en        = !skid_v;
  assign pix_ready = en;
  assign push      = en && vld[Last];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= Last; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[1] <= pix_valid;
      for (int k = 2; k <= Last; k++) vld[k] <= vld[k-1];
    end
  end

  // ---- stage 1: hue, saturation, mantissa
  logic signed [18:0] hue_raw;
  logic signed [18:0] hue_w;
  logic [16:0]        p1_hue;
  logic [16:0]        sat_d [1:19];
  logic [30:0]        lg_y  [1:17];
  logic [15:0]        lg_f  [1:17];
  logic [7:0]         lg_e  [1:17];
  logic [61:0]        lg_sq [2:17];

  assign hue_raw = HueBase - $signed({2'b00, alpha_deg, 2'b00});
  assign hue_w   = (hue_raw < 0) ? hue_raw + HueFull : hue_raw;

  always_comb begin
    for (int k = 2; k <= 17; k++) lg_sq[k] = lg_y[k-1] * lg_y[k-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_hue   <= hue_w[16:0];
      sat_d[1] <= 17'd65536 - {1'b0, entropy};
      lg_y[1]  <= {1'b1, lambda_bits[22:0], 7'b0};
      lg_f[1]  <= '0;
      lg_e[1]  <= lambda_bits[30:23];
      pv[1]    <= pixel_valid;
      for (int k = 2; k <= 19; k++) sat_d[k] <= sat_d[k-1];
      for (int k = 2; k <= Last; k++) pv[k] <= pv[k-1];
      // log2 fraction: square, renormalize, one bit per stage
      for (int k = 2; k <= 17; k++) begin
        lg_e[k] <= lg_e[k-1];
        if (lg_sq[k][61]) begin
          lg_y[k] <= lg_sq[k][61:31];
          lg_f[k] <= {lg_f[k-1][14:0], 1'b1};
        end else begin
          lg_y[k] <= lg_sq[k][60:30];
          lg_f[k] <= {lg_f[k-1][14:0], 1'b0};
        end
      end
    end
  end

  // ---- sector remainder and CORDIC angles
  logic [13:0] rem;
  logic [14:0] ang_t;
  logic [16:0] hs;

  always_comb begin
    if (p1_hue >= 5 * HueSector)      hs = p1_hue - 5 * HueSector;
    else if (p1_hue >= 4 * HueSector) hs = p1_hue - 4 * HueSector;
    else if (p1_hue >= 3 * HueSector) hs = p1_hue - 3 * HueSector;
    else if (p1_hue >= 2 * HueSector) hs = p1_hue - 2 * HueSector;
    else if (p1_hue >= HueSector)     hs = p1_hue - HueSector;
    else                              hs = p1_hue;
    rem   = hs[13:0];
    ang_t = Deg120Q8 - {1'b0, rem};
  end

  logic signed [19:0] st;
  logic signed [19:0] sh;
  logic signed [19:0] ch;

  phr_cordic u_cordic_sec (
    .clk   (clk),
    .en    (en),
    .angle ({2'b00, ang_t, 8'b0}),
    .sin_q (st),
    .cos_q ()
  );

  phr_cordic u_cordic_hue (
    .clk   (clk),
    .en    (en),
    .angle ({p1_hue, 8'b0}),
    .sin_q (sh),
    .cos_q (ch)
  );

  // ---- stage 18: dB product; stage 19: floor, clamp, range
  logic [8:0]         em;
  logic signed [24:0] l_q16;
  logic signed [43:0] p18_prod;
  logic               p18_ez;

  assign em    = {1'b0, lg_e[17]} - 9'd127;
  assign l_q16 = $signed({em, lg_f[17]});

  logic signed [19:0] db;
  logic signed [19:0] mn;
  logic signed [19:0] mx;
  logic signed [19:0] fl;
  logic signed [19:0] v0;
  logic signed [19:0] v1;
  logic signed [19:0] v2;
  logic signed [19:0] v3;
  logic signed [19:0] span;
  logic signed [19:0] dv;
  logic [17:0]        p19_d;
  logic [17:0]        p19_den;

  always_comb begin
    db   = p18_prod[43:24];
    mn   = 20'(min_db);
    mx   = 20'(max_db);
    fl   = 20'(floor_db);
    v0   = p18_ez ? fl : db;
    v1   = (v0 < fl) ? fl : v0;
    v2   = (v1 > mx) ? mx : v1;
    v3   = (v2 < mn) ? mn : v2;
    span = mx - mn;
    dv   = v3 - mn;
  end

  // ---- stage 20: chroma numerator
  logic [32:0] p20_n;
  logic [16:0] p20_st;

  always_ff @(posedge clk) begin
    if (en) begin
      p18_prod <= l_q16 * DbPerOctave;
      p18_ez   <= (lg_e[17] == 8'd0);
      // empty range gives 0/1
      if (span <= 0) begin
        p19_d   <= '0;
        p19_den <= 18'd1;
      end else begin
        p19_d   <= dv[17:0];
        p19_den <= span[17:0];
      end
      p20_n  <= sat_d[19] * ChromaK;
      p20_st <= (st < 1) ? 17'd1 : st[16:0];
    end
  end

  logic [QuoW-1:0] vn;
  logic [QuoW-1:0] cm;

  phr_div #(.DW(18), .QW(QuoW)) u_div_val (
    .clk  (clk),
    .en   (en),
    .r0   ({1'b0, p19_d[17:1]}),
    .low  ({p19_d[0], 16'b0}),
    .den  (p19_den),
    .quo  (vn)
  );

  phr_div #(.DW(17), .QW(QuoW)) u_div_chroma (
    .clk  (clk),
    .en   (en),
    .r0   ({2'b00, p20_n[31:17]}),
    .low  (p20_n[16:0]),
    .den  (p20_st),
    .quo  (cm)
  );

  // ---- delays to line up with the dividers
  logic signed [19:0] tc [20:37];
  logic signed [19:0] ts [20:37];
  logic [QuoW-1:0]    vn_d [37:39];

  always_ff @(posedge clk) begin
    if (en) begin
      tc[20] <= ch;
      ts[20] <= sh;
      for (int k = 21; k <= 37; k++) begin
        tc[k] <= tc[k-1];
        ts[k] <= ts[k-1];
      end
      vn_d[37] <= vn;
      vn_d[38] <= vn_d[37];
      vn_d[39] <= vn_d[38];
    end
  end

  // ---- stages 38..40: rotate chroma, mix, add value
  logic signed [37:0] pc1;
  logic signed [38:0] pc2;
  logic signed [22:0] p38_m1;
  logic signed [22:0] p38_m2;
  logic signed [40:0] p39_rm1;
  logic signed [40:0] p39_rm2;
  logic signed [40:0] p39_gm1;
  logic signed [40:0] p39_gm2;
  logic signed [40:0] p39_bm2;
  logic signed [41:0] sr;
  logic signed [41:0] sg;
  logic signed [41:0] sb;
  logic signed [26:0] p40_r;
  logic signed [26:0] p40_g;
  logic signed [26:0] p40_b;

  always_comb begin
    pc1 = $signed({1'b0, cm}) * tc[37];
    pc2 = -(39'($signed({1'b0, cm}) * ts[37]));
    sr  = 42'(p39_rm1) + 42'(p39_rm2);
    sg  = -42'(p39_gm1) - 42'(p39_gm2);
    sb  = -42'(p39_gm1) + 42'(p39_bm2);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p38_m1  <= 23'(pc1 >>> 16);
      p38_m2  <= 23'(pc2 >>> 16);
      p39_rm1 <= p38_m1 * CoefRm1;
      p39_rm2 <= p38_m2 * CoefRm2;
      p39_gm1 <= p38_m1 * CoefGm1;
      p39_gm2 <= p38_m2 * CoefGm2;
      p39_bm2 <= p38_m2 * CoefBm2;
      p40_r   <= 27'(sr >>> 16) + $signed({10'b0, vn_d[39]});
      p40_g   <= 27'(sg >>> 16) + $signed({10'b0, vn_d[39]});
      p40_b   <= 27'(sb >>> 16) + $signed({10'b0, vn_d[39]});
    end
  end

  function automatic logic [7:0] to8(input logic signed [26:0] c);
    logic [16:0] cc;
    logic [24:0] p;
    if (c < 0)             cc = '0;
    else if (c > 27'sd65536) cc = 17'd65536;
    else                   cc = c[16:0];
    p = {cc, 8'b0} - {8'b0, cc};
    return p[23:16];
  endfunction

  logic [7:0] r8;
  logic [7:0] g8;
  logic [7:0] b8;

  assign r8 = pv[Last] ? to8(p40_r) : 8'd0;
  assign g8 = pv[Last] ? to8(p40_g) : 8'd0;
  assign b8 = pv[Last] ? to8(p40_b) : 8'd0;

  // ---- output register plus skid
  logic [7:0] sk_r;
  logic [7:0] sk_g;
  logic [7:0] sk_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (!out_v || rgb_ready) begin
      if (skid_v) begin
        out_v  <= 1'b1;
        skid_v <= 1'b0;
      end else begin
        out_v <= push;
      end
    end else if (push) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v || rgb_ready) begin
      if (skid_v) begin
        red   <= sk_r;
        green <= sk_g;
        blue  <= sk_b;
      end else if (push) begin
        red   <= r8;
        green <= g8;
        blue  <= b8;
      end
    end else if (push) begin
      sk_r <= r8;
      sk_g <= g8;
      sk_b <= b8;
    end
  end

  assign rgb_valid = out_v;

endmodule

`default_nettype wire

/* hw/rtl/phr_checker.sv */
// Port-level checks for polarimetric_hsv_to_rgb_pixel_top, attached by bind.
// Sees only the top level ports; no package needed.
`default_nettype none

module phr_checker (
  input logic       clk,
  input logic       rst,
  input logic       pix_valid,
  input logic       pix_ready,
  input logic       rgb_valid,
  input logic       rgb_ready,
  input logic [7:0] red,
  input logic [7:0] green,
  input logic [7:0] blue
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !rgb_valid)
    else $error("rgb beat present after reset");

  // input backpressure only with a result parked at the output
  a_bp_needs_out: assert property (@(posedge clk) disable iff (rst)
    !pix_ready |-> rgb_valid)
    else $error("pix_ready low with no pending rgb beat");

  a_bp_cause: assert property (@(posedge clk) disable iff (rst)
    $fell(pix_ready) |-> $past(rgb_valid && !rgb_ready))
    else $error("pix_ready dropped without an output stall");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    rgb_valid && !rgb_ready |=> rgb_valid && $stable({red, green, blue}))
    else $error("stalled rgb beat changed");

endmodule

bind polarimetric_hsv_to_rgb_pixel_top phr_checker u_phr_checker (.*);

`default_nettype wire

/* test/polarimetric_hsv_to_rgb_pixel_top_test.sv */
// Self-checking bench for polarimetric_hsv_to_rgb_pixel_top: random and directed pixels,
// dB register sweeps, and a bit-exact color predictor inside a scoreboard class.
// Depends on phr_pkg and the pixel pipeline RTL.
`timescale 1ns / 100ps

module polarimetric_hsv_to_rgb_pixel_top_test;
  import phr_pkg::*;

  localparam int NumPhases = 7;
  localparam int IdleLimit = 5000;

  localparam longint ArcTan [16] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115
  };

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            pix_valid = 1'b0;
  logic            pix_ready;
  logic [14:0]     alpha_deg = '0;
  logic [15:0]     entropy = '0;
  logic [31:0]     lambda_bits = '0;
  logic            pixel_valid = 1'b0;
  logic            rgb_valid;
  logic            rgb_ready = 1'b0;
  logic [7:0]      red, green, blue;
  logic            cfg_we = 1'b0;
  logic [1:0]      cfg_index = '0;
  logic [CfgW-1:0] cfg_data = '0;

  bit calm = 1'b0;
  int idle_cycles = 0;

  polarimetric_hsv_to_rgb_pixel_top dut (.*);

  always #5 clk = ~clk;

  class color_scoreboard;
    longint lo_db, hi_db, floor_lvl;
    logic [23:0] rgb_expected[$];
    int pixels_in, colors_out, mismatches;

    function new();
      lo_db = -6400;
      hi_db = 0;
      floor_lvl = -76800;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CfgW-1:0] d);
      longint v;
      v = longint'($signed(d));
      case (idx)
        CFG_MIN_DB: lo_db = v;
        CFG_MAX_DB: hi_db = v;
        default:    floor_lvl = v;
      endcase
    endfunction

    // angle in Q.16 degrees; results truncated to Q.16
    function void sin_cos(input longint a, output longint s, output longint c);
      longint x, y, z, dx, dy;
      bit neg;
      neg = 1'b0;
      x = 652032874;
      y = 0;
      if (a > 270 * 65536) begin
        a -= 360 * 65536;
      end else if (a > 90 * 65536) begin
        a -= 180 * 65536;
        neg = 1'b1;
      end
      z = a;
      for (int i = 0; i < 16; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= ArcTan[i];
        end else begin
          x += dx; y -= dy; z += ArcTan[i];
        end
      end
      if (neg) begin
        x = -x; y = -y;
      end
      c = x >>> 14;
      s = y >>> 14;
    endfunction

    function longint level_db(logic [31:0] b);
      longint unsigned m;
      longint frac, l;
      m = (64'd1 << 30) | (64'(b[22:0]) << 7);
      frac = 0;
      for (int i = 0; i < 16; i++) begin
        m = (m * m) >> 30;
        frac = frac << 1;
        if (m >= (64'd2 << 30)) begin
          frac |= 1;
          m >>= 1;
        end
      end
      l = (longint'(b[30:23]) - 127) * 65536 + frac;
      return (l * 197283) >>> 24;
    endfunction

    function longint to8(longint c);
      if (c < 0) c = 0;
      if (c > 65536) c = 65536;
      return (255 * c) >> 16;
    endfunction

    function logic [23:0] pixel_color(logic [14:0] a, logic [15:0] e,
                                      logic [31:0] b, logic pv);
      longint hue, sat, v, vn, st, ct, sh, ch, cm, m1, m2;
      if (!pv) return 24'd0;
      hue = 76800 - 4 * longint'(a);
      if (hue > 92160) hue -= 92160;
      if (hue < 0) hue += 92160;
      sat = 65536 - longint'(e);
      if (b[30:23] == 8'd0) v = floor_lvl;
      else v = level_db(b);
      if (v < floor_lvl) v = floor_lvl;
      if (v > hi_db) v = hi_db;
      if (v < lo_db) v = lo_db;
      if (hi_db <= lo_db) vn = 0;
      else vn = ((v - lo_db) * 65536) / (hi_db - lo_db);
      sin_cos((30720 - hue % 15360) * 256, st, ct);
      if (st < 1) st = 1;
      cm = (sat * 56756) / st;
      sin_cos(hue * 256, sh, ch);
      m1 = (cm * ch) >>> 16;
      m2 = (-(cm * sh)) >>> 16;
      return {8'(to8(vn + ((51610 * m1 + 24340 * m2) >>> 16))),
              8'(to8(vn + ((-13926 * m1 - 13494 * m2) >>> 16))),
              8'(to8(vn + ((-13926 * m1 + 62181 * m2) >>> 16)))};
    endfunction

    function void note_pixel(logic [14:0] a, logic [15:0] e, logic [31:0] b, logic pv);
      rgb_expected.push_back(pixel_color(a, e, b, pv));
      pixels_in++;
    endfunction

    function void check_color(logic [7:0] r, logic [7:0] g, logic [7:0] bl);
      logic [23:0] want;
      colors_out++;
      if (rgb_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected color beat r=%0d g=%0d b=%0d", r, g, bl);
        return;
      end
      want = rgb_expected.pop_front();
      if (want !== {r, g, bl}) begin
        mismatches++;
        if (mismatches <= 10)
          $display("color mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                   want[23:16], want[15:8], want[7:0], r, g, bl);
      end
    endfunction
  endclass

  color_scoreboard sb = new();

  // receiver: random stall bursts, none once calm
  int stall_left = 0;
  always @(negedge clk) begin
    if (calm) begin
      rgb_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      rgb_ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 2);
      rgb_ready <= 1'b0;
    end else begin
      rgb_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && rgb_valid && rgb_ready) sb.check_color(red, green, blue);
    if (rst || (rgb_valid && rgb_ready) || (pix_valid && pix_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no beat for %0d cycles", IdleLimit);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic send_pixel(logic [14:0] a, logic [15:0] e, logic [31:0] b, logic pv);
    int gap;
    gap = (!calm && $urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      pix_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix_valid <= 1'b1;
    alpha_deg <= a;
    entropy <= e;
    lambda_bits <= b;
    pixel_valid <= pv;
    do @(posedge clk); while (!pix_ready);
    sb.note_pixel(a, e, b, pv);
    @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CfgW-1:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, d);
  endtask

  // drain the pipeline before touching registers
  task automatic settle();
    pix_valid <= 1'b0;
    @(negedge clk);
    wait (sb.rgb_expected.size() == 0);
    repeat (60) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_lambda();
    int k;
    k = $urandom_range(0, 19);
    if (k < 14) return {$urandom_range(0, 1) == 1, 8'(127 + $urandom_range(0, 80) - 40),
                        23'($urandom)};
    if (k < 16) return {$urandom_range(0, 1) == 1, 8'd0, 23'($urandom)};
    if (k < 17) return {$urandom_range(0, 1) == 1, 8'd255, 23'($urandom)};
    return $urandom;
  endfunction

  task automatic random_pixels(int n);
    logic [14:0] a;
    for (int i = 0; i < n; i++) begin
      a = ($urandom_range(0, 7) == 0) ? 15'($urandom) : 15'($urandom_range(0, 23040));
      send_pixel(a, 16'($urandom), rand_lambda(), $urandom_range(0, 9) != 0);
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: field extremes and the special lambda encodings
    send_pixel(15'd0, 16'd0, 32'h3F80_0000, 1'b1);
    send_pixel(15'd23040, 16'd65535, 32'h3F80_0000, 1'b1);
    send_pixel(15'd32767, 16'd0, 32'h3C23_D70A, 1'b1);
    send_pixel(15'd5760, 16'd32768, 32'h0000_0000, 1'b1);
    send_pixel(15'd7680, 16'd0, 32'h0000_0001, 1'b1);
    send_pixel(15'd11520, 16'd0, 32'h807F_FFFF, 1'b1);
    send_pixel(15'd15360, 16'd100, 32'h7F80_0000, 1'b1);
    send_pixel(15'd19200, 16'd0, 32'hFFFF_FFFF, 1'b1);
    send_pixel(15'd3840, 16'd0, 32'h7FFF_FFFF, 1'b1);
    send_pixel(15'd17280, 16'd0, 32'h0080_0000, 1'b1);
    send_pixel(15'd23040, 16'd0, 32'hBF80_0000, 1'b1);
    send_pixel(15'd24000, 16'd40000, 32'h3DCC_CCCD, 1'b1);
    send_pixel(15'd32767, 16'd65535, 32'hFFFF_FFFF, 1'b0);
    send_pixel(15'd0, 16'd0, 32'h0000_0000, 1'b0);
    send_pixel(15'd1920, 16'd12345, 32'h4120_0000, 1'b1);
    send_pixel(15'd1, 16'd1, 32'h3F7F_FFFF, 1'b1);

    for (int p = 0; p < NumPhases; p++) begin
      settle();
      case (p)
        0: ;
        1: begin
          write_reg(CFG_MIN_DB, 18'h20000);
          write_reg(CFG_MAX_DB, 18'h1FFFF);
          write_reg(CFG_FLOOR_DB, 18'h20000);
        end
        2: begin
          // empty range
          write_reg(CFG_MIN_DB, 18'(-2560));
          write_reg(CFG_MAX_DB, 18'(-2560));
        end
        3: begin
          write_reg(CFG_MIN_DB, 18'h1FFFF);
          write_reg(CFG_MAX_DB, 18'h20000);
          write_reg(CFG_FLOOR_DB, 18'h1FFFF);
        end
        4: begin
          // floor lands inside the range
          write_reg(CFG_MIN_DB, 18'(-10240));
          write_reg(CFG_MAX_DB, 18'd2560);
          write_reg(CFG_FLOOR_DB, 18'(-5120));
        end
        default: begin
          write_reg(CFG_MIN_DB, 18'(-$urandom_range(0, 20000)));
          write_reg(CFG_MAX_DB, 18'($urandom_range(0, 8000)));
          write_reg(CFG_FLOOR_DB, 18'(-$urandom_range(0, 80000)));
        end
      endcase
      if (p == NumPhases - 1) calm = 1'b1;
      random_pixels(175);
    end

    pix_valid <= 1'b0;
    wait (sb.rgb_expected.size() == 0);
    repeat (60) @(negedge clk);
    $display("Sent %0d pixels over %0d dB register settings, checked %0d colors, %0d bad.",
             sb.pixels_in, NumPhases, sb.colors_out, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
